// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] item_value;
      logic signed [15:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic signed [15:0] removed_priority;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] item_value;
      logic signed [15:0] item_priority;
   } entry_type;

   // per-cell control from the queue head logic
   typedef struct packed {
      logic ins;       // insert transaction this cycle
      logic del;       // delete transaction this cycle
      logic occupied;  // cell holds an entry
      logic tail;      // first empty cell
   } cell_ctl_type;

endpackage

// ===== rtl/core/sorted_priority_queue_core.sv =====
// Bounded sorted priority queue of spq_pkg::DEPTH entries held in a row of
// compare-and-shift cells. An insert places the entry behind every held entry
// of lower or equal priority; a delete returns the head entry. Every
// transaction gives one response: status ok, underflow (delete when empty) or
// overflow (insert when full, queue unchanged), the removed entry (zero unless
// a delete succeeds) and the occupancy after the operation. One transaction
// is taken per cycle; the response appears in the next cycle from an output
// register, and the request side stalls only while that register is full and
// stalled. Entry contents need no clearing after reset.
module sorted_priority_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic      req_fire;
   logic      is_insert, is_delete;
   logic      full, empty;
   logic      do_ins, do_del;
   entry_type new_entry;

   entry_type    cell_entry [DEPTH];
   logic         cell_gt    [DEPTH];
   cell_ctl_type cell_ctl   [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign is_insert = (req_data.opcode == OP_INSERT);
   assign is_delete = (req_data.opcode == OP_DELETE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_ins    = req_fire && is_insert && !full;
   assign do_del    = req_fire && is_delete && !empty;

   assign new_entry.item_value    = req_data.item_value;
   assign new_entry.item_priority = req_data.item_priority;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         entry_type left_e;
         logic      left_g;
         entry_type right_e;

         assign cell_ctl[i].ins      = do_ins;
         assign cell_ctl[i].del      = do_del;
         assign cell_ctl[i].occupied = (CNT_W'(i) < count_ff);
         assign cell_ctl[i].tail     = (CNT_W'(i) == count_ff);

         if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_g = 1'b0;
         end else begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_e = cell_entry[i];
         end else begin : g_mid
            assign right_e = cell_entry[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in                  = rsp_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (req_fire) begin
         rsp_valid_in            = 1'b1;
         rsp_in.status           = ST_OK;
         rsp_in.removed_value    = '0;
         rsp_in.removed_priority = '0;
         rsp_in.occupancy        = 5'(count_in);
         if (is_insert && full) begin
            rsp_in.status = ST_OVERFLOW;
         end else if (is_delete && empty) begin
            rsp_in.status = ST_UNDERFLOW;
         end else if (is_delete) begin
            rsp_in.removed_value    = cell_entry[0].item_value;
            rsp_in.removed_priority = cell_entry[0].item_priority;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/spq_cell.sv =====
module spq_cell (
   input  logic                clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type  new_entry,
   input  spq_pkg::entry_type  left_entry,
   input  logic                left_gt,
   input  spq_pkg::entry_type  right_entry,
   output spq_pkg::entry_type  entry,
   output logic                gt
);
   import spq_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   assign entry = data_ff;
   assign gt    = ctl.occupied &&
                  ($signed(data_ff.item_priority) > $signed(new_entry.item_priority));

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (left_gt) begin
            data_in = left_entry;
         end else if (gt || ctl.tail) begin
            data_in = new_entry;
         end
      end else if (ctl.del) begin
         data_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
